[design/nst_pkg.sv]
`timescale 1ns / 1ps
// constants, operation codes and status codes for the named semaphore table
// no dependencies
package nst_pkg;

    localparam int SEM_SLOTS   = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(SEM_SLOTS);
    localparam int POS_W       = $clog2(QUEUE_DEPTH);
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH   = SEM_SLOTS << POS_W;
    localparam int ADDR_W      = SLOT_W + POS_W;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [2:0] K_OPEN   = 3'd0;
    localparam logic [2:0] K_CLOSE  = 3'd1;
    localparam logic [2:0] K_WAIT   = 3'd2;
    localparam logic [2:0] K_POST   = 3'd3;
    localparam logic [2:0] K_REMOVE = 3'd4;
    localparam logic [2:0] K_READ   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_WAITERS   = 3'd3;
    localparam logic [2:0] ST_QFULL     = 3'd4;
    localparam logic [2:0] ST_BLOCKED   = 3'd5;

endpackage

[design/named_semaphore_table.sv]
`timescale 1ns / 1ps
// named semaphore table: 16 keyed counting semaphores, each with a fifo of waiters
// depends on nst_pkg
// open/close/wait/read scan the keys sequentially, slot by slot, then execute;
// post with queued waiters reads the head waiter, then shifts the queue down through the pid ram,
// which has one read and one write port; remove scans the queues entry by entry for the pid.
// one transaction at a time; busy is high until the result strobe, which cannot be stalled.
// synchronous active-low reset clears slot flags, queue lengths and control, not the pid ram, slot keys or counts
module named_semaphore_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_sem_key,
    input  logic [15:0] i_pid,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_count,
    output logic        o_wake_valid,
    output logic [15:0] o_wake_pid
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FIND    = 4'd1;
    localparam logic [3:0] S_EXEC    = 4'd2;
    localparam logic [3:0] S_PO_RD   = 4'd3;
    localparam logic [3:0] S_PO_CAP  = 4'd4;
    localparam logic [3:0] S_SH_RD   = 4'd5;
    localparam logic [3:0] S_SH_WR   = 4'd6;
    localparam logic [3:0] S_RM_SLOT = 4'd7;
    localparam logic [3:0] S_RM_RD   = 4'd8;
    localparam logic [3:0] S_RM_CMP  = 4'd9;

    localparam logic [nst_pkg::SLOT_W-1:0] LAST_SLOT = nst_pkg::SLOT_W'(nst_pkg::SEM_SLOTS - 1);
    localparam logic [nst_pkg::LEN_W-1:0]  QDEPTH    = nst_pkg::LEN_W'(nst_pkg::QUEUE_DEPTH);

    logic [3:0]                     r_state;
    logic [2:0]                     r_kind;
    logic [31:0]                    r_key;
    logic [15:0]                    r_pid;
    logic [nst_pkg::SLOT_W-1:0]     r_slot;
    logic [nst_pkg::SLOT_W-1:0]     r_free;
    logic                           r_free_ok;
    logic                           r_found;
    logic [nst_pkg::LEN_W-1:0]      r_pos;

    logic [nst_pkg::SEM_SLOTS-1:0]  r_used;
    logic [31:0]                    r_slot_key [nst_pkg::SEM_SLOTS];
    logic [15:0]                    r_slot_count [nst_pkg::SEM_SLOTS];
    logic [nst_pkg::LEN_W-1:0]      r_qlen [nst_pkg::SEM_SLOTS];

    logic [15:0]                    r_mem [nst_pkg::MEM_DEPTH];
    logic [15:0]                    r_rdata;
    logic                           mem_we;
    logic [nst_pkg::ADDR_W-1:0]     mem_waddr;
    logic [nst_pkg::ADDR_W-1:0]     mem_raddr;
    logic [15:0]                    mem_wdata;

    logic                           r_valid;
    logic [2:0]                     r_status;
    logic [15:0]                    r_count;
    logic                           r_wake_valid;
    logic [15:0]                    r_wake_pid;

    logic [nst_pkg::LEN_W-1:0]      cur_len;
    logic [15:0]                    cur_count;
    logic [nst_pkg::LEN_W:0]        pos_next;

    assign cur_len   = r_qlen[r_slot];
    assign cur_count = r_slot_count[r_slot];
    assign pos_next  = {1'b0, r_pos} + 1'b1;

    // pid ram ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_slot, r_pos[nst_pkg::POS_W-1:0]};
        mem_wdata = r_rdata;
        mem_raddr = {r_slot, r_pos[nst_pkg::POS_W-1:0]};
        unique case (r_state)
            S_EXEC: begin
                mem_waddr = {r_slot, cur_len[nst_pkg::POS_W-1:0]};
                mem_wdata = r_pid;
                mem_we    = r_found && (r_kind == nst_pkg::K_WAIT) && (cur_count == 16'd0)
                            && (cur_len < QDEPTH);
            end
            S_PO_RD:  mem_raddr = {r_slot, {nst_pkg::POS_W{1'b0}}};
            S_SH_RD:  mem_raddr = {r_slot, pos_next[nst_pkg::POS_W-1:0]};
            S_SH_WR:  mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot       <= '0;
            r_used       <= '0;
            r_valid      <= 1'b0;
            r_wake_valid <= 1'b0;
            for (int i = 0; i < nst_pkg::SEM_SLOTS; i++) begin
                r_qlen[i] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind       <= i_kind;
                        r_key        <= i_sem_key;
                        r_pid        <= i_pid;
                        r_slot       <= '0;
                        r_free_ok    <= 1'b0;
                        r_wake_valid <= 1'b0;
                        r_wake_pid   <= 16'd0;
                        if (i_kind > nst_pkg::K_READ) begin
                            r_valid  <= 1'b1;
                            r_status <= nst_pkg::ST_NOT_FOUND;
                            r_count  <= 16'd0;
                        end else if (i_kind == nst_pkg::K_REMOVE) begin
                            r_state <= S_RM_SLOT;
                        end else begin
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    if (r_used[r_slot] && r_slot_key[r_slot] == r_key) begin
                        r_found <= 1'b1;
                        r_state <= S_EXEC;
                    end else begin
                        if (!r_used[r_slot] && !r_free_ok) begin
                            r_free    <= r_slot;
                            r_free_ok <= 1'b1;
                        end
                        if (r_slot == LAST_SLOT) begin
                            r_found <= 1'b0;
                            r_state <= S_EXEC;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                        end
                    end
                end
                S_EXEC: begin
                    r_state  <= S_IDLE;
                    r_valid  <= 1'b1;
                    r_status <= nst_pkg::ST_NOT_FOUND;
                    r_count  <= 16'd0;
                    case (r_kind)
                        nst_pkg::K_OPEN: begin
                            if (r_found) begin
                                r_status <= nst_pkg::ST_OK;
                                r_count  <= cur_count;
                            end else if (r_free_ok) begin
                                r_used[r_free]       <= 1'b1;
                                r_slot_key[r_free]   <= r_key;
                                r_slot_count[r_free] <= 16'd1;
                                r_qlen[r_free]       <= '0;
                                r_status             <= nst_pkg::ST_OK;
                                r_count              <= 16'd1;
                            end else begin
                                r_status <= nst_pkg::ST_FULL;
                            end
                        end
                        nst_pkg::K_CLOSE: begin
                            if (r_found) begin
                                if (cur_len != '0) begin
                                    r_status <= nst_pkg::ST_WAITERS;
                                    r_count  <= cur_count;
                                end else begin
                                    r_used[r_slot] <= 1'b0;
                                    r_status       <= nst_pkg::ST_OK;
                                end
                            end
                        end
                        nst_pkg::K_WAIT: begin
                            if (r_found) begin
                                if (cur_count != 16'd0) begin
                                    r_slot_count[r_slot] <= cur_count - 1'b1;
                                    r_status             <= nst_pkg::ST_OK;
                                    r_count              <= cur_count - 1'b1;
                                end else if (cur_len >= QDEPTH) begin
                                    r_status <= nst_pkg::ST_QFULL;
                                end else begin
                                    r_qlen[r_slot] <= cur_len + 1'b1;
                                    r_status       <= nst_pkg::ST_BLOCKED;
                                end
                            end
                        end
                        nst_pkg::K_POST: begin
                            if (r_found) begin
                                if (cur_len != '0) begin
                                    // hand over to the head waiter
                                    r_valid <= 1'b0;
                                    r_state <= S_PO_RD;
                                end else begin
                                    if (cur_count != nst_pkg::COUNT_MAX) begin
                                        r_slot_count[r_slot] <= cur_count + 1'b1;
                                        r_count              <= cur_count + 1'b1;
                                    end else begin
                                        r_count <= cur_count;
                                    end
                                    r_status <= nst_pkg::ST_OK;
                                end
                            end
                        end
                        nst_pkg::K_READ: begin
                            if (r_found) begin
                                r_status <= nst_pkg::ST_OK;
                                r_count  <= cur_count;
                            end
                        end
                        default: ;
                    endcase
                end
                S_PO_RD: begin
                    r_state <= S_PO_CAP;
                end
                S_PO_CAP: begin
                    r_wake_valid <= 1'b1;
                    r_wake_pid   <= r_rdata;
                    r_pos        <= '0;
                    r_state      <= S_SH_RD;
                end
                S_SH_RD: begin
                    if (pos_next < {1'b0, cur_len}) begin
                        r_state <= S_SH_WR;
                    end else begin
                        // compaction done, shorten queue and report
                        r_qlen[r_slot] <= cur_len - 1'b1;
                        r_valid        <= 1'b1;
                        r_status       <= nst_pkg::ST_OK;
                        r_count        <= cur_count;
                        r_state        <= S_IDLE;
                    end
                end
                S_SH_WR: begin
                    r_pos   <= pos_next[nst_pkg::LEN_W-1:0];
                    r_state <= S_SH_RD;
                end
                S_RM_SLOT: begin
                    if (r_used[r_slot] && cur_len != '0) begin
                        r_pos   <= '0;
                        r_state <= S_RM_RD;
                    end else if (r_slot == LAST_SLOT) begin
                        r_valid  <= 1'b1;
                        r_status <= nst_pkg::ST_NOT_FOUND;
                        r_count  <= 16'd0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_RM_RD: begin
                    r_state <= S_RM_CMP;
                end
                S_RM_CMP: begin
                    if (r_rdata == r_pid) begin
                        r_state <= S_SH_RD;
                    end else if (pos_next < {1'b0, cur_len}) begin
                        r_pos   <= pos_next[nst_pkg::LEN_W-1:0];
                        r_state <= S_RM_RD;
                    end else if (r_slot == LAST_SLOT) begin
                        r_valid  <= 1'b1;
                        r_status <= nst_pkg::ST_NOT_FOUND;
                        r_count  <= 16'd0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_RM_SLOT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_count      = r_count;
    assign o_wake_valid = r_valid & r_wake_valid;
    assign o_wake_pid   = r_wake_valid ? r_wake_pid : 16'd0;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind <= nst_pkg::K_READ) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_wake_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wake_valid |-> (o_status == nst_pkg::ST_OK && r_kind == nst_pkg::K_POST))
        else $error("wake outside a successful post");

    a_qlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_len <= QDEPTH)
        else $error("queue length beyond depth");

endmodule
